/* hw/rtl/wsd_pkg.sv */
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared request types and result codes of the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // frame actions
    localparam logic [1:0] ACT_BINARY = 2'd0;
    localparam logic [1:0] ACT_CLOSE  = 2'd1;
    localparam logic [1:0] ACT_PING   = 2'd2;
    localparam logic [1:0] ACT_PONG   = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_SHORT_HEADER = 3'd1;
    localparam logic [2:0] ERR_NO_FIN       = 3'd2;
    localparam logic [2:0] ERR_RSV          = 3'd3;
    localparam logic [2:0] ERR_NO_MASK      = 3'd4;
    localparam logic [2:0] ERR_LEN64        = 3'd5;
    localparam logic [2:0] ERR_LEN_MISMATCH = 3'd6;
    localparam logic [2:0] ERR_BAD_OPCODE   = 3'd7;

    // opcodes that are accepted
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // header field constants
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // input request
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       segment_end;
    } in_t;

    // result request
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [1:0] action;
        logic       last_of_payload;
        logic [2:0] error_code;
    } out_t;

endpackage

/* hw/rtl/websocket_frame_deframer_core.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core
// Client frame deframer: header checks, length, mask key, unmasked payload.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while s_ready is high; its result, if
// any, is registered in the result register. The header decode, the length
// counter and the unmasking xor all sit in one combinational pass between the
// s_ port and the result register, so the sustained rate is one byte per cycle
// unless m_ready holds results back. A skid stage behind the result register
// lets the block keep taking bytes while a result waits; s_ready drops only
// when both stages are full. There is no clearing pass after reset.
module websocket_frame_deframer_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  wsd_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output wsd_pkg::out_t m_data
);

    // frame phases
    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXT     = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAY     = 3'd4;
    localparam logic [2:0] PH_SWALLOW = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  hidx_reg, hidx_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic [15:0] remain_reg, remain_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  midx_reg, midx_next;
    logic        disc_reg, disc_next;
    logic        fin_reg, fin_next;
    logic        rsv_reg, rsv_next;
    logic        ext_reg, ext_next;
    logic [2:0]  pend_reg, pend_next;

    logic          out_valid_reg, skid_valid_reg;
    wsd_pkg::out_t out_data_reg, skid_data_reg;

    logic          accept;
    logic          res_valid;
    wsd_pkg::out_t res;
    logic          err;
    logic [2:0]    err_code;
    logic          act_ok;
    logic [1:0]    act;
    logic [1:0]    k;
    logic [15:0]   remain_dec;
    logic [7:0]    b;
    logic          se;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;
    assign b       = s_data.rx_byte;
    assign se      = s_data.segment_end;

    // opcode classification
    always_comb begin
        act_ok = 1'b1;
        act    = wsd_pkg::ACT_BINARY;
        case (opcode_reg)
            wsd_pkg::OP_BINARY: act = wsd_pkg::ACT_BINARY;
            wsd_pkg::OP_CLOSE:  act = wsd_pkg::ACT_CLOSE;
            wsd_pkg::OP_PING:   act = wsd_pkg::ACT_PING;
            wsd_pkg::OP_PONG:   act = wsd_pkg::ACT_PONG;
            default:            act_ok = 1'b0;
        endcase
    end

    assign k          = 2'(hidx_reg[1:0] - (ext_reg ? 2'd0 : 2'd2));
    assign remain_dec = 16'(remain_reg - 16'd1);

    // per-byte frame decode
    always_comb begin
        phase_next  = phase_reg;
        hidx_next   = hidx_reg;
        opcode_next = opcode_reg;
        remain_next = remain_reg;
        key_next    = key_reg;
        midx_next   = midx_reg;
        disc_next   = disc_reg;
        fin_next    = fin_reg;
        rsv_next    = rsv_reg;
        ext_next    = ext_reg;
        pend_next   = pend_reg;
        res_valid   = 1'b0;
        res         = '0;
        err         = 1'b0;
        err_code    = wsd_pkg::ERR_NONE;

        if (disc_reg) begin
            if (se) begin
                disc_next  = 1'b0;
                phase_next = PH_HDR0;
                hidx_next  = 3'd0;
            end
        end else begin
            case (phase_reg)
                PH_HDR0: begin
                    fin_next    = b[7];
                    rsv_next    = |b[6:4];
                    opcode_next = b[3:0];
                    hidx_next   = 3'd1;
                    phase_next  = PH_HDR1;
                    if (se) begin
                        err      = 1'b1;
                        err_code = wsd_pkg::ERR_SHORT_HEADER;
                    end
                end
                PH_HDR1: begin
                    if (!fin_reg)                       pend_next = wsd_pkg::ERR_NO_FIN;
                    else if (rsv_reg)                   pend_next = wsd_pkg::ERR_RSV;
                    else if (!b[7])                     pend_next = wsd_pkg::ERR_NO_MASK;
                    else if (b[6:0] == wsd_pkg::LEN_EXT64) pend_next = wsd_pkg::ERR_LEN64;
                    else                                pend_next = wsd_pkg::ERR_NONE;
                    ext_next    = (b[6:0] == wsd_pkg::LEN_EXT16);
                    remain_next = {9'd0, b[6:0]};
                    key_next    = '0;
                    midx_next   = 2'd0;
                    hidx_next   = 3'd2;
                    phase_next  = (b[6:0] == wsd_pkg::LEN_EXT16) ? PH_EXT : PH_MASK;
                    if (se) begin
                        err      = 1'b1;
                        err_code = wsd_pkg::ERR_SHORT_HEADER;
                    end
                end
                PH_EXT: begin
                    if (hidx_reg == 3'd2) begin
                        remain_next = {b, 8'd0};
                    end else begin
                        remain_next = {remain_reg[15:8], b};
                        phase_next  = PH_MASK;
                    end
                    hidx_next = 3'(hidx_reg + 3'd1);
                    if (se) begin
                        err      = 1'b1;
                        err_code = wsd_pkg::ERR_SHORT_HEADER;
                    end
                end
                PH_MASK: begin
                    // collect key byte into its lane
                    for (int j = 0; j < 4; j++) begin
                        if (k == 2'(j)) begin
                            key_next[8*j +: 8] = key_reg[8*j +: 8] | b;
                        end
                    end
                    hidx_next = 3'(hidx_reg + 3'd1);
                    if (hidx_reg == 3'd5 && pend_reg != wsd_pkg::ERR_NONE) begin
                        err      = 1'b1;
                        err_code = pend_reg;
                    end else if (k != 2'd3) begin
                        if (se) begin
                            err      = 1'b1;
                            err_code = wsd_pkg::ERR_SHORT_HEADER;
                        end
                    end else begin
                        hidx_next = 3'd0;
                        midx_next = 2'd0;
                        if (remain_reg == 16'd0) begin
                            if (!se) begin
                                err      = 1'b1;
                                err_code = wsd_pkg::ERR_LEN_MISMATCH;
                            end else if (!act_ok) begin
                                err      = 1'b1;
                                err_code = wsd_pkg::ERR_BAD_OPCODE;
                            end else begin
                                res_valid           = 1'b1;
                                res.kind            = wsd_pkg::KIND_EMPTY;
                                res.action          = act;
                                res.last_of_payload = 1'b1;
                                phase_next          = PH_HDR0;
                            end
                        end else if (se) begin
                            err      = 1'b1;
                            err_code = wsd_pkg::ERR_LEN_MISMATCH;
                        end else begin
                            phase_next = act_ok ? PH_PAY : PH_SWALLOW;
                        end
                    end
                end
                PH_PAY: begin
                    midx_next   = 2'(midx_reg + 2'd1);
                    remain_next = remain_dec;
                    if (remain_dec == 16'd0 ? !se : se) begin
                        err      = 1'b1;
                        err_code = wsd_pkg::ERR_LEN_MISMATCH;
                    end else begin
                        res_valid           = 1'b1;
                        res.kind            = wsd_pkg::KIND_PAYLOAD;
                        res.data            = b ^ key_reg[8*midx_reg +: 8];
                        res.action          = act;
                        res.last_of_payload = (remain_dec == 16'd0);
                        if (remain_dec == 16'd0) begin
                            phase_next = PH_HDR0;
                        end
                    end
                end
                PH_SWALLOW: begin
                    remain_next = remain_dec;
                    if (remain_dec == 16'd0) begin
                        err      = 1'b1;
                        err_code = se ? wsd_pkg::ERR_BAD_OPCODE : wsd_pkg::ERR_LEN_MISMATCH;
                    end else if (se) begin
                        err      = 1'b1;
                        err_code = wsd_pkg::ERR_LEN_MISMATCH;
                    end
                end
                default: begin
                    phase_next = PH_HDR0;
                    hidx_next  = 3'd0;
                end
            endcase

            // error report overrides the frame progress
            if (err) begin
                res_valid      = 1'b1;
                res            = '0;
                res.kind       = wsd_pkg::KIND_ERROR;
                res.error_code = err_code;
                disc_next      = !se;
                phase_next     = PH_HDR0;
                hidx_next      = 3'd0;
            end
        end
    end

    // frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR0;
            hidx_reg   <= 3'd0;
            opcode_reg <= 4'd0;
            remain_reg <= 16'd0;
            key_reg    <= 32'd0;
            midx_reg   <= 2'd0;
            disc_reg   <= 1'b0;
            fin_reg    <= 1'b0;
            rsv_reg    <= 1'b0;
            ext_reg    <= 1'b0;
            pend_reg   <= wsd_pkg::ERR_NONE;
        end else if (accept) begin
            phase_reg  <= phase_next;
            hidx_reg   <= hidx_next;
            opcode_reg <= opcode_next;
            remain_reg <= remain_next;
            key_reg    <= key_next;
            midx_reg   <= midx_next;
            disc_reg   <= disc_next;
            fin_reg    <= fin_next;
            rsv_reg    <= rsv_next;
            ext_reg    <= ext_next;
            pend_reg   <= pend_next;
        end
    end

    // result register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg  <= skid_valid_reg || (accept && res_valid);
            skid_valid_reg <= 1'b0;
        end else if (accept && res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res;
        end else if (accept && res_valid) begin
            skid_data_reg <= res;
        end
    end

endmodule

/* hw/rtl/wsd_checker.sv */
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks of the websocket frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module wsd_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input wsd_pkg::out_t m_data
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // reset leaves both stages empty
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result pending after reset");

    // error results carry only a nonzero code
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == wsd_pkg::KIND_ERROR |->
            m_data.error_code != wsd_pkg::ERR_NONE && m_data.data == 8'd0 &&
            m_data.action == wsd_pkg::ACT_BINARY && !m_data.last_of_payload)
        else $error("malformed error result");

    // empty frame closes the frame and has no data
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == wsd_pkg::KIND_EMPTY |->
            m_data.last_of_payload && m_data.data == 8'd0 &&
            m_data.error_code == wsd_pkg::ERR_NONE)
        else $error("malformed empty frame result");

    // only defined kinds appear, payload has no error code
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.kind <= wsd_pkg::KIND_ERROR &&
            (m_data.kind != wsd_pkg::KIND_PAYLOAD ||
             m_data.error_code == wsd_pkg::ERR_NONE))
        else $error("bad result kind");

endmodule

bind websocket_frame_deframer_core wsd_checker u_wsd_checker (.*);
